### hw/rtl/obdd_pkg.sv
package obdd_pkg;

    // first header byte that selects the three byte header
    localparam logic [7:0] EXT_CODE    = 8'h62;
    // adapter prompt that closes a response
    localparam logic [7:0] PROMPT_CHAR = 8'h3E;

    localparam logic [1:0] SKIP_SHORT = 2'd2;
    localparam logic [1:0] SKIP_LONG  = 2'd3;
    localparam logic [7:0] INDEX_MAX  = 8'hFF;

    typedef struct packed {
        logic       nibble_pending;
        logic [3:0] high_nibble;
        logic [1:0] header_count;
        logic       extended_header;
        logic [7:0] held_byte;
        logic       held_valid;
        logic [7:0] payload_index;
    } obdd_state_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       last;
    } obdd_result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } obdd_hex_t;

    function automatic obdd_hex_t hex_decode(input logic [7:0] c);
        obdd_hex_t  h;
        logic [7:0] d;
        h = '0;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            h.is_hex = 1'b1;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            h.is_hex = 1'b1;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            h.is_hex = 1'b1;
        end
        h.value = d[3:0];
        return h;
    endfunction

endpackage

### hw/rtl/obd_response_deframer.sv
// OBD response deframer: takes the characters of adapter replies one word at a time
// and returns the payload bytes with their header stripped. Non-hex characters are
// skipped, hex digits pair up high nibble first, the first byte of a response picks a
// three byte header when it is 0x62 and a two byte header otherwise. One payload byte
// is always held back so that the '>' prompt can release it with last set; a prompt
// with nothing held emits nothing, and an odd trailing nibble is dropped. mode = 1
// (disconnect) clears the partial response without output. byte_index counts from 0
// and sticks at 255. Rate: one character per clock while out_ready keeps the result
// register drained. A character is taken into the input register when accepted, and
// the state update loads the result register once that register is free or being
// emptied. in_ready depends on out_ready through the output stage, so a stalled
// result lets one more character wait in the input register.
module obd_response_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] rx_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic       last
);
    import obdd_pkg::*;

    // input register
    logic         in_valid_reg;
    logic         mode_reg;
    logic [7:0]   char_reg;

    // deframer state and result register
    obdd_state_t  state_reg;
    obdd_state_t  state_next;
    obdd_result_t result;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [7:0]   data_byte_reg;
    logic [7:0]   byte_index_reg;
    logic         last_reg;

    logic         advance;

    // a buffered word moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    obdd_step u_step (
        .state      (state_reg),
        .mode       (mode_reg),
        .rx_char    (char_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    // payload of the input register needs no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            mode_reg <= mode;
            char_reg <= rx_char;
        end
    end

    always_comb
    begin
        if (advance) begin
            out_valid_next = result.emit;
        end else begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit) begin
            data_byte_reg  <= result.data_byte;
            byte_index_reg <= result.byte_index;
            last_reg       <= result.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_byte_reg;
    assign byte_index = byte_index_reg;
    assign last       = last_reg;

    // a held byte only exists once the header has been counted
    a_held_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.held_valid |-> state_reg.header_count != 2'd0)
        else $error("held byte without header");

    // index only advances while a byte is held
    a_index_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.payload_index != 8'd0 |-> state_reg.held_valid)
        else $error("payload index set with nothing held");

    // a prompt or disconnect leaves no partial response behind
    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (mode_reg || char_reg == PROMPT_CHAR)
        |=> !state_reg.held_valid && state_reg.header_count == 2'd0
            && !state_reg.nibble_pending)
        else $error("partial state survived end of response");

    // a waiting result is never overwritten or lost
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("stalled result dropped");

    // an empty input register always takes a word
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stalled while empty");

endmodule

### hw/rtl/obdd_step.sv
module obdd_step (
    input  obdd_pkg::obdd_state_t  state,
    input  logic                   mode,
    input  logic [7:0]             rx_char,
    output obdd_pkg::obdd_state_t  state_next,
    output obdd_pkg::obdd_result_t result
);
    import obdd_pkg::*;

    obdd_hex_t  hex;
    logic [7:0] full_byte;
    logic [1:0] skip;

    assign hex       = hex_decode(rx_char);
    assign full_byte = {state.high_nibble, hex.value};
    assign skip      = state.extended_header ? SKIP_LONG : SKIP_SHORT;

    always_comb
    begin
        state_next        = state;
        result.emit       = 1'b0;
        result.data_byte  = state.held_byte;
        result.byte_index = state.payload_index;
        result.last       = 1'b0;
        if (mode) begin
            // disconnect drops everything, held word included
            state_next = '0;
        end else if (rx_char == PROMPT_CHAR) begin
            result.emit = state.held_valid;
            result.last = 1'b1;
            state_next  = '0;
        end else if (hex.is_hex) begin
            if (!state.nibble_pending) begin
                state_next.high_nibble    = hex.value;
                state_next.nibble_pending = 1'b1;
            end else begin
                state_next.nibble_pending = 1'b0;
                if (state.header_count == 2'd0) begin
                    state_next.extended_header = (full_byte == EXT_CODE);
                    state_next.header_count    = 2'd1;
                end else if (state.header_count < skip) begin
                    state_next.header_count = state.header_count + 2'd1;
                end else begin
                    // release the previous byte, hold this one for the prompt
                    if (state.held_valid) begin
                        result.emit = 1'b1;
                        if (state.payload_index != INDEX_MAX) begin
                            state_next.payload_index = state.payload_index + 8'd1;
                        end
                    end
                    state_next.held_byte  = full_byte;
                    state_next.held_valid = 1'b1;
                end
            end
        end
    end

endmodule
